>>> rtl/sebe_pkg.sv
// Shared types, constants and controller states for the shift-escape encoder.
package sebe_pkg;

    localparam int MAX_LEN = 31;
    localparam logic [7:0] QUOTE_CHAR = 8'd39;
    localparam logic [7:0] EMPTY_CHAR = 8'h78;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_message;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
        logic       overflow;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HIST_WR,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_HEAD,
        ST_FETCH,
        ST_BYTE,
        ST_ESC2,
        ST_EMPTY
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic store_byte;
        logic clear_msg;
        logic clr_step;
        logic scan_init;
        logic scan_rd;
        logic scan_ev;
        logic scan_next;
        logic emit_load;
        logic emit_kind;     // 0 head, 1 byte/escape
        logic fetch;
        logic esc2;
        logic emit_empty;
        logic rd_next;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic clr_done;
        logic scan_done;
        logic cnt_zero;
        logic rd_last;
        logic need_esc;
        logic out_busy;
    } t_stat;

endpackage

>>> rtl/sebe_ctrl.sv
// Controller state machine for the shift-escape encoder.
module sebe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sebe_pkg::t_in_word i_word,
    input  sebe_pkg::t_stat   i_stat,
    output logic              o_stall,
    output sebe_pkg::t_cmd    o_cmd
);
    sebe_pkg::t_state r_state, n_state;

    // Hold state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sebe_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            sebe_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = sebe_pkg::ST_IDLE;
                end
            end
            sebe_pkg::ST_IDLE: begin
                o_stall = i_stat.out_busy;
                if (i_valid && !i_stat.out_busy) begin
                    if (i_word.empty_message) begin
                        o_cmd.emit_empty = 1'b1;
                        n_state = sebe_pkg::ST_EMPTY;
                    end else begin
                        o_cmd.store_byte = 1'b1;
                        if (i_word.last_byte) begin
                            n_state = sebe_pkg::ST_HIST_WR;
                        end
                    end
                end
            end
            // Let the last histogram increment land before the scan reads.
            sebe_pkg::ST_HIST_WR: begin
                n_state = sebe_pkg::ST_SCAN_RD;
            end
            sebe_pkg::ST_EMPTY: begin
                o_cmd.clear_msg = 1'b1;
                n_state = sebe_pkg::ST_CLEAR;
            end
            sebe_pkg::ST_SCAN_RD: begin
                o_cmd.scan_init = 1'b1;
                o_cmd.scan_rd = 1'b1;
                n_state = sebe_pkg::ST_SCAN_EV;
            end
            sebe_pkg::ST_SCAN_EV: begin
                o_cmd.scan_ev = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = sebe_pkg::ST_HEAD;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            sebe_pkg::ST_HEAD: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_stat.cnt_zero) begin
                        o_cmd.clear_msg = 1'b1;
                        n_state = sebe_pkg::ST_CLEAR;
                    end else begin
                        o_cmd.fetch = 1'b1;
                        n_state = sebe_pkg::ST_BYTE;
                    end
                end
            end
            sebe_pkg::ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state = sebe_pkg::ST_BYTE;
            end
            sebe_pkg::ST_BYTE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit_load = 1'b1;
                    o_cmd.emit_kind = 1'b1;
                    if (i_stat.need_esc) begin
                        n_state = sebe_pkg::ST_ESC2;
                    end else if (i_stat.rd_last) begin
                        o_cmd.clear_msg = 1'b1;
                        n_state = sebe_pkg::ST_CLEAR;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                        n_state = sebe_pkg::ST_FETCH;
                    end
                end
            end
            sebe_pkg::ST_ESC2: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit_load = 1'b1;
                    o_cmd.esc2 = 1'b1;
                    if (i_stat.rd_last) begin
                        o_cmd.clear_msg = 1'b1;
                        n_state = sebe_pkg::ST_CLEAR;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                        n_state = sebe_pkg::ST_FETCH;
                    end
                end
            end
            default: begin
                n_state = sebe_pkg::ST_CLEAR;
            end
        endcase
    end
endmodule

>>> rtl/sebe_dp.sv
// Datapath: byte store, histogram memory, shift scan and output register.
module sebe_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sebe_pkg::t_in_word i_word,
    input  sebe_pkg::t_cmd     i_cmd,
    input  logic               i_out_stall,
    output sebe_pkg::t_stat    o_stat,
    output logic               o_valid,
    output sebe_pkg::t_out_word o_word
);
    logic [7:0] r_store [sebe_pkg::MAX_LEN];
    logic [4:0] r_hist_a [256];
    logic [4:0] r_hist_b [256];
    logic [4:0] r_hist_c [256];

    logic [4:0] r_count;
    logic       r_ovf;
    logic [7:0] r_clr_idx;
    logic [7:0] r_s;
    logic [7:0] r_best_shift;
    logic [5:0] r_best_esc;
    logic       r_found;
    logic [4:0] r_ha, r_hb, r_hc;
    logic [4:0] r_rd_idx;
    logic [7:0] r_rd_byte;
    logic [7:0] r_code;
    logic       r_valid;
    sebe_pkg::t_out_word r_word;
    logic       r_inc_en;
    logic [7:0] r_inc_addr;

    logic [7:0] w_b;
    logic [6:0] w_sum;
    logic [7:0] w_c;
    logic       w_esc;
    logic       w_last_rd;
    logic       w_wr_en;
    logic [7:0] w_wr_addr;
    logic [4:0] w_wr_data;
    logic [4:0] r_cur;

    assign w_b = i_word.data_byte;
    assign w_sum = {2'b0, r_ha} + {2'b0, r_hb} + {2'b0, r_hc};
    assign w_c = r_rd_byte - r_best_shift;
    assign w_esc = (w_c == 8'd0) || (w_c == 8'd1) || (w_c == sebe_pkg::QUOTE_CHAR);
    assign w_last_rd = ({1'b0, r_rd_idx} + 6'd1) == {1'b0, r_count};

    // Histogram write: clearing sweep or increment of the byte stored last cycle.
    assign w_wr_en = i_cmd.clr_step || r_inc_en;
    assign w_wr_addr = i_cmd.clr_step ? r_clr_idx : r_inc_addr;
    assign w_wr_data = i_cmd.clr_step ? 5'd0 : r_cur + 5'd1;

    // Write the three histogram copies; read the bin of a stored byte and the scan bins.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_hist_a[w_wr_addr] <= w_wr_data;
            r_hist_b[w_wr_addr] <= w_wr_data;
            r_hist_c[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.store_byte) begin
            // Forward the pending increment when the same value follows.
            r_cur      <= (r_inc_en && (r_inc_addr == w_b)) ? r_cur + 5'd1 : r_hist_a[w_b];
            r_inc_addr <= w_b;
        end
        if (i_cmd.scan_rd || i_cmd.scan_next) begin
            r_ha <= r_hist_a[i_cmd.scan_next ? r_s + 8'd1 : 8'd1];
            r_hb <= r_hist_b[i_cmd.scan_next ? r_s + 8'd2 : 8'd2];
            r_hc <= r_hist_c[i_cmd.scan_next ? r_s + 8'd40 : 8'd40];
        end
    end

    // Store bytes and read them back.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte && (r_count != 5'(sebe_pkg::MAX_LEN))) begin
            r_store[r_count] <= w_b;
        end
        if (i_cmd.fetch) begin
            r_rd_byte <= r_store[r_rd_idx];
        end
    end

    // Control registers: counts, scan and emit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_clr_idx    <= '0;
            r_s          <= 8'd1;
            r_best_shift <= 8'd1;
            r_best_esc   <= '0;
            r_found      <= 1'b0;
            r_rd_idx     <= '0;
            r_valid      <= 1'b0;
            r_inc_en     <= 1'b0;
        end else begin
            r_inc_en <= i_cmd.store_byte && (r_count != 5'(sebe_pkg::MAX_LEN));
            if (o_valid && !i_out_stall) begin
                r_valid <= 1'b0;
            end
            if (i_cmd.clr_step) begin
                r_clr_idx <= r_clr_idx + 8'd1;
            end
            if (i_cmd.store_byte) begin
                if (r_count != 5'(sebe_pkg::MAX_LEN)) begin
                    r_count <= r_count + 5'd1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.scan_init) begin
                r_s          <= 8'd1;
                r_best_shift <= 8'd1;
                r_best_esc   <= {1'b0, r_count};
                r_found      <= 1'b0;
            end
            if (i_cmd.scan_ev) begin
                if (!r_found && (r_s != sebe_pkg::QUOTE_CHAR)
                    && (w_sum < {1'b0, r_best_esc})) begin
                    r_best_esc   <= w_sum[5:0];
                    r_best_shift <= r_s;
                    if (w_sum == 7'd0) begin
                        r_found <= 1'b1;
                    end
                end
                if (i_cmd.scan_next) begin
                    r_s <= r_s + 8'd1;
                end
            end
            if (i_cmd.rd_next) begin
                r_rd_idx <= r_rd_idx + 5'd1;
            end
            if (i_cmd.emit_load || i_cmd.emit_empty) begin
                r_valid <= 1'b1;
            end
            if (i_cmd.clear_msg) begin
                r_count      <= '0;
                r_ovf        <= 1'b0;
                r_clr_idx    <= '0;
                r_best_shift <= 8'd1;
                r_best_esc   <= '0;
                r_rd_idx     <= '0;
            end
        end
    end

    // Load the output word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_empty) begin
            r_word <= '{out_char: sebe_pkg::EMPTY_CHAR, last_char: 1'b1, overflow: 1'b0};
        end else if (i_cmd.emit_load) begin
            if (i_cmd.esc2) begin
                r_word <= '{out_char: r_code, last_char: w_last_rd, overflow: r_ovf};
            end else if (i_cmd.emit_kind) begin
                if (w_esc) begin
                    r_word <= '{out_char: 8'd1, last_char: 1'b0, overflow: r_ovf};
                end else begin
                    r_word <= '{out_char: w_c, last_char: w_last_rd, overflow: r_ovf};
                end
            end else begin
                r_word <= '{out_char: r_best_shift, last_char: (r_count == 5'd0),
                            overflow: r_ovf};
            end
        end
        if (i_cmd.emit_load && i_cmd.emit_kind) begin
            r_code <= (w_c == 8'd0) ? 8'd1 : (w_c == 8'd1) ? 8'd2 : 8'd3;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_stat.clr_done  = (r_clr_idx == 8'hff);
    assign o_stat.scan_done = r_found || (r_s == 8'hff);
    assign o_stat.cnt_zero  = (r_count == 5'd0);
    assign o_stat.rd_last   = w_last_rd;
    assign o_stat.need_esc  = w_esc;
    assign o_stat.out_busy  = r_valid && i_out_stall;
endmodule

>>> rtl/shift_escape_binary_encoder.sv
// Top level of the shift-escape binary encoder.
// Takes a message one word at a time, one word per cycle while storing and while no
// stalled output word holds it off. After the word marked last the block waits in a
// histogram-write state for the histogram update, then scans shifts 1..255 through
// its histogram memory, one shift per cycle, stopping early on a zero-escape hit, then
// emits the shift and each encoded byte while the receiver takes them, plus a
// clearing pass over all 256 histogram bins after reset and after every message,
// during which no input word is accepted.
module shift_escape_binary_encoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  sebe_pkg::t_in_word   i_word,
    output logic                 o_valid,
    input  logic                 i_stall,
    output sebe_pkg::t_out_word  o_word
);
    sebe_pkg::t_cmd  w_cmd;
    sebe_pkg::t_stat w_stat;

    sebe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_word  (i_word),
        .i_stat  (w_stat),
        .o_stall (o_stall),
        .o_cmd   (w_cmd)
    );

    sebe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (i_word),
        .i_cmd       (w_cmd),
        .i_out_stall (i_stall),
        .o_stat      (w_stat),
        .o_valid     (o_valid),
        .o_word      (o_word)
    );

    // Never load a new output word over one that is stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !(w_cmd.emit_load || w_cmd.emit_empty))
        else $error("output word overwritten while stalled");

    // An empty-message word always yields 'x' flagged last.
    a_empty_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit_empty |=> (o_valid && o_word.last_char
                              && o_word.out_char == sebe_pkg::EMPTY_CHAR))
        else $error("empty message output wrong");

    // No input is taken while the scan or emit runs.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.scan_ev || w_cmd.fetch) |-> o_stall)
        else $error("input accepted while busy");
endmodule

>>> bench/tb_shift_escape_binary_encoder.sv
// Testbench for the shift-escape binary encoder: directed and random messages checked against a predictor.
`timescale 1ns / 100ps

module tb_shift_escape_binary_encoder;

    // Scoreboard: predicts encoded words per message and checks the block's output.
    class encoder_scoreboard;
        logic [7:0] msg_bytes[sebe_pkg::MAX_LEN];
        logic [4:0] bin_count[256];
        int         msg_len;
        bit         dropped;
        sebe_pkg::t_out_word pending_chars[$];
        int         errors;
        int         words_checked;

        function void clear_msg();
            foreach (bin_count[k]) bin_count[k] = '0;
            msg_len = 0;
            dropped = 1'b0;
        endfunction

        function new();
            errors = 0;
            words_checked = 0;
            clear_msg();
        endfunction

        function void push_char(logic [7:0] ch, logic fin, logic ovf);
            sebe_pkg::t_out_word w;
            w.out_char = ch;
            w.last_char = fin;
            w.overflow = ovf;
            pending_chars.push_back(w);
        endfunction

        // Note one accepted input word and queue the characters it causes.
        function void note_input(sebe_pkg::t_in_word w);
            int s, total, best_sum;
            logic [7:0] shift, c;
            if (w.empty_message) begin
                push_char(sebe_pkg::EMPTY_CHAR, 1'b1, 1'b0);
                clear_msg();
                return;
            end
            if (msg_len < sebe_pkg::MAX_LEN) begin
                msg_bytes[msg_len] = w.data_byte;
                bin_count[w.data_byte] = bin_count[w.data_byte] + 5'd1;
                msg_len++;
            end else begin
                dropped = 1'b1;
            end
            if (!w.last_byte)
                return;
            // Pick the first shift with the fewest escapes, stop early at zero.
            shift = 8'd1;
            best_sum = msg_len;
            for (s = 1; s < 256; s++) begin
                if (s == sebe_pkg::QUOTE_CHAR)
                    continue;
                total = bin_count[s] + bin_count[(s + 1) % 256]
                      + bin_count[(s + sebe_pkg::QUOTE_CHAR) % 256];
                if (total < best_sum) begin
                    best_sum = total;
                    shift = s[7:0];
                    if (total == 0)
                        break;
                end
            end
            push_char(shift, msg_len == 0, dropped);
            for (int i = 0; i < msg_len; i++) begin
                c = msg_bytes[i] - shift;
                if (c == 8'd0 || c == 8'd1 || c == sebe_pkg::QUOTE_CHAR) begin
                    push_char(8'd1, 1'b0, dropped);
                    push_char(c == 8'd0 ? 8'd1 : c == 8'd1 ? 8'd2 : 8'd3,
                              i + 1 == msg_len, dropped);
                end else begin
                    push_char(c, i + 1 == msg_len, dropped);
                end
            end
            clear_msg();
        endfunction

        // Check one accepted output word against the oldest prediction.
        function void check_output(sebe_pkg::t_out_word got);
            sebe_pkg::t_out_word exp_w;
            if (pending_chars.size() == 0) begin
                $error("unexpected output word %h", got);
                errors++;
                return;
            end
            exp_w = pending_chars.pop_front();
            words_checked++;
            if (got.out_char !== exp_w.out_char) begin
                $error("out_char: expected %h, got %h", exp_w.out_char, got.out_char);
                errors++;
            end
            if (got.last_char !== exp_w.last_char) begin
                $error("last_char: expected %b, got %b", exp_w.last_char, got.last_char);
                errors++;
            end
            if (got.overflow !== exp_w.overflow) begin
                $error("overflow: expected %b, got %b", exp_w.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    sebe_pkg::t_in_word  i_word;
    logic      o_valid;
    logic      i_stall;
    sebe_pkg::t_out_word o_word;

    encoder_scoreboard board;
    int  msgs_sent;
    bit  hold_off;

    shift_escape_binary_encoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Half the time no gap, otherwise mostly a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one word and hold it until accepted; drop valid only over a gap.
    task automatic send_word(logic [7:0] b, logic fin, logic empty);
        sebe_pkg::t_in_word w;
        int g;
        w.data_byte = b;
        w.last_byte = fin;
        w.empty_message = empty;
        i_valid <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (o_stall);
        board.note_input(w);
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Send a whole message; kind picks the byte pattern, some force escapes.
    task automatic send_message(int len, int kind);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (kind)
                0: b = 8'($urandom_range(0, 255));
                1: b = 8'($urandom_range(0, 3));
                2: b = 8'(i);
                default: b = (i % 2) ? 8'hff : 8'h00;
            endcase
            send_word(b, i == len - 1, 1'b0);
        end
        msgs_sent++;
    endtask

    // Receiver: random stalls, plus the long hold-off when asked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                board.check_output(o_word);
            i_stall <= hold_off || ($urandom_range(0, 99) < 25);
        end
    end

    initial begin
        #5_000_000;
        $display("tb_shift_escape_binary_encoder: FAIL");
        $finish;
    end

    initial begin
        int wait_cycles;
        board = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_word = '0;
        hold_off = 1'b0;
        msgs_sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single bytes at the extremes, escape values, empties.
        send_message(1, 3);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'd39, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'h12, 1'b0, 1'b0);
        send_word(8'h34, 1'b0, 1'b1);
        send_message(4, 1);
        send_message(sebe_pkg::MAX_LEN, 2);
        // Overflow: 34 bytes into a 31-byte store.
        send_message(34, 0);
        send_message(8, 3);

        // Long receiver hold-off while the sender keeps going.
        fork
            begin
                hold_off = 1'b1;
                repeat (2000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                send_message(sebe_pkg::MAX_LEN, 1);
                send_message(8, 0);
            end
        join

        // Random messages, mostly short, sometimes overlong or empty.
        for (int n = 0; n < 4; n++) begin
            int r;
            r = $urandom_range(0, 9);
            if (r == 0)
                send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            else if (r == 1)
                send_message($urandom_range(32, 36), $urandom_range(0, 3));
            else
                send_message($urandom_range(1, 8), $urandom_range(0, 3));
        end
        i_valid <= 1'b0;

        wait_cycles = 0;
        while (board.pending_chars.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (600) @(posedge i_clk);

        $display("Covered %0d messages with %0d output words checked.",
                 msgs_sent, board.words_checked);
        if (board.errors == 0 && board.pending_chars.size() == 0)
            $display("tb_shift_escape_binary_encoder: PASS");
        else
            $display("tb_shift_escape_binary_encoder: FAIL");
        $finish;
    end

endmodule
